FILE: rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg: shared definitions for the JSON string unescaper
// Character codes, decoder modes, status codes, the queued record type and
// the sizing constants used by the front end, the queue and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

   // Width of the decoded byte counter.
   localparam int LEN_BITS = 16;
   // Width of the length compare, wide enough for the counter and the limit register.
   localparam int SUM_W = ((LEN_BITS > 16) ? LEN_BITS : 16) + 1;

   // Queue between the front end and the back end.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // Reset value of the length limit register.
   localparam logic [15:0] MAX_BYTES_RESET = 16'd511;

   // Decoder modes.
   localparam logic [2:0] M_IDLE = 3'd0;
   localparam logic [2:0] M_BODY = 3'd1;
   localparam logic [2:0] M_ESC  = 3'd2;
   localparam logic [2:0] M_HEX1 = 3'd3;
   localparam logic [2:0] M_SBSL = 3'd4;
   localparam logic [2:0] M_SU   = 3'd5;
   localparam logic [2:0] M_HEX2 = 3'd6;

   // Status codes carried by every result.
   localparam logic [1:0] ST_CONT   = 2'd0;
   localparam logic [1:0] ST_CLOSED = 2'd1;
   localparam logic [1:0] ST_ERROR  = 2'd2;

   // Character codes.
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_SLASH  = 8'h2f;
   localparam logic [7:0] CH_CTRL   = 8'h20;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_N      = 8'h6e;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_U      = 8'h75;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_FF     = 8'h0c;
   localparam logic [7:0] CH_LF     = 8'h0a;
   localparam logic [7:0] CH_CR     = 8'h0d;
   localparam logic [7:0] CH_TAB    = 8'h09;

   // Surrogate ranges.
   localparam logic [15:0] HI_SUR_LO = 16'hd800;
   localparam logic [15:0] HI_SUR_HI = 16'hdbff;
   localparam logic [15:0] LO_SUR_LO = 16'hdc00;
   localparam logic [15:0] LO_SUR_HI = 16'hdfff;

   // One queued record: the results caused by one input item.
   typedef struct packed {
      logic [3:0][7:0] bytes;     // decoded bytes, entry 0 first
      logic [1:0]      last_idx;  // index of the final result
      logic [1:0]      status;    // status shared by all results
   } rec_type;

endpackage

`default_nettype wire

FILE: rtl/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front: input decoder of the JSON string unescaper
// Accepts one raw byte per cycle while accept is high, tracks the escape
// state, encodes code points as UTF-8, checks the length limit and emits
// one record per item that causes results.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_front (
   input  wire              clock,
   input  wire              reset,
   // Input item
   input  wire              accept,
   input  wire [7:0]        in_byte,
   input  wire              at_end,
   // Limit register write
   input  wire              cfg_write,
   input  wire [15:0]       cfg_data,
   // Record towards the queue
   output logic             rec_push,
   output jsu_pkg::rec_type rec
);

   localparam logic [jsu_pkg::SUM_W-1:0] LEN_MAX =
      jsu_pkg::SUM_W'((64'd1 << jsu_pkg::LEN_BITS) - 64'd1);

   logic [15:0]                  max_bytes_ff;
   logic [2:0]                   mode_ff, mode_in;
   logic [1:0]                   hex_left_ff, hex_left_in;
   logic [15:0]                  code_acc_ff, code_acc_in;
   logic [9:0]                   high_half_ff, high_half_in;
   logic [jsu_pkg::LEN_BITS-1:0] count_ff, count_in;

   logic                         hex_ok;
   logic [3:0]                   hex_val;
   logic [15:0]                  acc_shift;
   logic [10:0]                  plane;
   logic [20:0]                  cp_sup;
   logic [2:0]                   n;
   logic [1:0]                   st;
   logic [3:0][7:0]              bytes;
   logic [jsu_pkg::SUM_W-1:0]    sum;
   logic [jsu_pkg::SUM_W-1:0]    limit;

   // Hex digit decode.
   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
         hex_val = 4'(in_byte - 8'h30);
      end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
         hex_val = 4'(in_byte - 8'h57);
      end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
         hex_val = 4'(in_byte - 8'h37);
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign acc_shift = {code_acc_ff[11:0], hex_val};
   // Supplementary code point from the stored high half and the low surrogate.
   assign plane     = {1'b0, high_half_ff} + 11'd64;
   assign cp_sup    = {plane, acc_shift[9:0]};

   // Effective length limit.
   always_comb begin
      limit = jsu_pkg::SUM_W'(max_bytes_ff);
      if (LEN_MAX < limit) begin
         limit = LEN_MAX;
      end
   end

   assign sum = jsu_pkg::SUM_W'(count_ff) + jsu_pkg::SUM_W'(n);

   // Decoder next state and results of the current item.
   always_comb begin
      mode_in      = mode_ff;
      hex_left_in  = hex_left_ff;
      code_acc_in  = code_acc_ff;
      high_half_in = high_half_ff;
      count_in     = count_ff;
      n            = 3'd0;
      st           = jsu_pkg::ST_CONT;
      bytes        = '0;

      case (mode_ff)
         jsu_pkg::M_BODY: begin
            if (in_byte == jsu_pkg::CH_QUOTE) begin
               st = jsu_pkg::ST_CLOSED;
            end else if (in_byte < jsu_pkg::CH_CTRL) begin
               st = jsu_pkg::ST_ERROR;
            end else if (in_byte == jsu_pkg::CH_BSLASH) begin
               mode_in = jsu_pkg::M_ESC;
            end else begin
               bytes[0] = in_byte;
               n        = 3'd1;
            end
         end
         jsu_pkg::M_ESC: begin
            mode_in = jsu_pkg::M_BODY;
            case (in_byte)
               jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: begin
                  bytes[0] = in_byte;
                  n        = 3'd1;
               end
               jsu_pkg::CH_B: begin
                  bytes[0] = jsu_pkg::CH_BS;
                  n        = 3'd1;
               end
               jsu_pkg::CH_F: begin
                  bytes[0] = jsu_pkg::CH_FF;
                  n        = 3'd1;
               end
               jsu_pkg::CH_N: begin
                  bytes[0] = jsu_pkg::CH_LF;
                  n        = 3'd1;
               end
               jsu_pkg::CH_R: begin
                  bytes[0] = jsu_pkg::CH_CR;
                  n        = 3'd1;
               end
               jsu_pkg::CH_T: begin
                  bytes[0] = jsu_pkg::CH_TAB;
                  n        = 3'd1;
               end
               jsu_pkg::CH_U: begin
                  mode_in     = jsu_pkg::M_HEX1;
                  hex_left_in = 2'd3;
                  code_acc_in = 16'd0;
               end
               default: begin
                  st = jsu_pkg::ST_ERROR;
               end
            endcase
         end
         jsu_pkg::M_HEX1, jsu_pkg::M_HEX2: begin
            if (!hex_ok) begin
               st = jsu_pkg::ST_ERROR;
            end else begin
               code_acc_in = acc_shift;
               if (hex_left_ff != 2'd0) begin
                  hex_left_in = hex_left_ff - 2'd1;
               end else if (mode_ff == jsu_pkg::M_HEX1) begin
                  if (acc_shift >= jsu_pkg::HI_SUR_LO && acc_shift <= jsu_pkg::HI_SUR_HI) begin
                     // High surrogate: the range is aligned, so the low ten bits are the half.
                     high_half_in = acc_shift[9:0];
                     mode_in      = jsu_pkg::M_SBSL;
                  end else if (acc_shift >= jsu_pkg::LO_SUR_LO &&
                               acc_shift <= jsu_pkg::LO_SUR_HI) begin
                     st = jsu_pkg::ST_ERROR;
                  end else begin
                     mode_in = jsu_pkg::M_BODY;
                     if (acc_shift <= 16'h007f) begin
                        bytes[0] = acc_shift[7:0];
                        n        = 3'd1;
                     end else if (acc_shift <= 16'h07ff) begin
                        bytes[0] = {3'b110, acc_shift[10:6]};
                        bytes[1] = {2'b10, acc_shift[5:0]};
                        n        = 3'd2;
                     end else begin
                        bytes[0] = {4'b1110, acc_shift[15:12]};
                        bytes[1] = {2'b10, acc_shift[11:6]};
                        bytes[2] = {2'b10, acc_shift[5:0]};
                        n        = 3'd3;
                     end
                  end
               end else begin
                  if (acc_shift < jsu_pkg::LO_SUR_LO || acc_shift > jsu_pkg::LO_SUR_HI) begin
                     st = jsu_pkg::ST_ERROR;
                  end else begin
                     mode_in  = jsu_pkg::M_BODY;
                     bytes[0] = {5'b11110, cp_sup[20:18]};
                     bytes[1] = {2'b10, cp_sup[17:12]};
                     bytes[2] = {2'b10, cp_sup[11:6]};
                     bytes[3] = {2'b10, cp_sup[5:0]};
                     n        = 3'd4;
                  end
               end
            end
         end
         jsu_pkg::M_SBSL: begin
            if (in_byte == jsu_pkg::CH_BSLASH) begin
               mode_in = jsu_pkg::M_SU;
            end else begin
               st = jsu_pkg::ST_ERROR;
            end
         end
         jsu_pkg::M_SU: begin
            if (in_byte == jsu_pkg::CH_U) begin
               mode_in     = jsu_pkg::M_HEX2;
               hex_left_in = 2'd3;
               code_acc_in = 16'd0;
            end else begin
               st = jsu_pkg::ST_ERROR;
            end
         end
         default: begin
            // Idle and unused codes wait for the opening quote.
            if (in_byte == jsu_pkg::CH_QUOTE) begin
               mode_in      = jsu_pkg::M_BODY;
               hex_left_in  = 2'd0;
               code_acc_in  = 16'd0;
               high_half_in = 10'd0;
               count_in     = '0;
            end else begin
               st = jsu_pkg::ST_ERROR;
            end
         end
      endcase

      // Length limit check.
      if (st == jsu_pkg::ST_CONT && n != 3'd0) begin
         if (sum > limit) begin
            st = jsu_pkg::ST_ERROR;
         end else begin
            count_in = sum[jsu_pkg::LEN_BITS-1:0];
         end
      end

      // End of data inside an open string.
      if (st == jsu_pkg::ST_CONT && at_end) begin
         st = jsu_pkg::ST_ERROR;
      end

      // Completion or error returns to idle.
      if (st != jsu_pkg::ST_CONT) begin
         mode_in      = jsu_pkg::M_IDLE;
         hex_left_in  = 2'd0;
         code_acc_in  = 16'd0;
         high_half_in = 10'd0;
         count_in     = '0;
      end
   end

   // Record for the back end; an ending item gives one result without data.
   always_comb begin
      rec_push = accept && (st != jsu_pkg::ST_CONT || n != 3'd0);
      rec.status = st;
      if (st != jsu_pkg::ST_CONT) begin
         rec.bytes    = '0;
         rec.last_idx = 2'd0;
      end else begin
         rec.bytes    = bytes;
         rec.last_idx = 2'(n - 3'd1);
      end
   end

   // Decoder state and limit register.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_bytes_ff <= jsu_pkg::MAX_BYTES_RESET;
         mode_ff      <= jsu_pkg::M_IDLE;
         hex_left_ff  <= 2'd0;
         code_acc_ff  <= 16'd0;
         high_half_ff <= 10'd0;
         count_ff     <= '0;
      end else begin
         if (cfg_write) begin
            max_bytes_ff <= cfg_data;
         end
         if (accept) begin
            mode_ff      <= mode_in;
            hex_left_ff  <= hex_left_in;
            code_acc_ff  <= code_acc_in;
            high_half_ff <= high_half_in;
            count_ff     <= count_in;
         end
      end
   end

endmodule

`default_nettype wire

FILE: rtl/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue: record queue between decoder and result sequencer
// A small register queue that lets the front end keep accepting bytes while
// the back end is still emitting the bytes of earlier records.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_queue (
   input  wire              clock,
   input  wire              reset,
   input  wire              push,
   input  jsu_pkg::rec_type push_data,
   output logic             full,
   input  wire              pop,
   output jsu_pkg::rec_type pop_data,
   output logic             empty
);

   jsu_pkg::rec_type               mem_ff [jsu_pkg::QUEUE_DEPTH];
   logic [jsu_pkg::QUEUE_AW-1:0]   wr_ptr_ff;
   logic [jsu_pkg::QUEUE_AW-1:0]   rd_ptr_ff;
   logic [jsu_pkg::QUEUE_AW:0]     count_ff;
   logic                           do_push;
   logic                           do_pop;

   assign full     = (count_ff == (jsu_pkg::QUEUE_AW+1)'(jsu_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // Storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + jsu_pkg::QUEUE_AW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + jsu_pkg::QUEUE_AW'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + (jsu_pkg::QUEUE_AW+1)'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - (jsu_pkg::QUEUE_AW+1)'(1);
         end
      end
   end

endmodule

`default_nettype wire

FILE: rtl/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back: result sequencer of the JSON string unescaper
// Holds one record and presents its results one per cycle on the result
// channel while rsp_pop is high, loading the next record when none is held
// or as the last result of the current one is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_back (
   input  wire              clock,
   input  wire              reset,
   // Record from the queue
   input  jsu_pkg::rec_type q_data,
   input  wire              q_empty,
   output logic             q_pop,
   // Result channel
   output logic             rsp_empty,
   input  wire              rsp_pop,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_out_valid,
   output logic             rsp_out_last,
   output logic [1:0]       rsp_status
);

   jsu_pkg::rec_type cur_ff;
   logic             cur_valid_ff;
   logic [1:0]       idx_ff;
   logic             is_last;
   logic             take;

   assign is_last = (idx_ff == cur_ff.last_idx);
   assign take    = rsp_pop && cur_valid_ff;
   assign q_pop   = !q_empty && (!cur_valid_ff || (take && is_last));

   // Result fields from the held record.
   assign rsp_empty     = !cur_valid_ff;
   assign rsp_out_byte  = cur_ff.bytes[idx_ff];
   assign rsp_out_valid = (cur_ff.status == jsu_pkg::ST_CONT);
   assign rsp_out_last  = is_last;
   assign rsp_status    = cur_ff.status;

   // Record payload.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_data;
      end
   end

   // Held record valid flag and result index.
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         if (q_pop) begin
            cur_valid_ff <= 1'b1;
            idx_ff       <= 2'd0;
         end else if (take) begin
            if (is_last) begin
               cur_valid_ff <= 1'b0;
               idx_ff       <= 2'd0;
            end else begin
               idx_ff <= idx_ff + 2'd1;
            end
         end
      end
   end

endmodule

`default_nettype wire

FILE: rtl/json_string_unescape_utf8.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8: JSON string unescaper with UTF-8 output
// Decodes the raw bytes of one quoted JSON string into UTF-8 bytes.
// ----------------------------------------------------------------------------
// Usage:
// Raw bytes enter on the req_ channel, one item per cycle, accepted when
// req_push is high and req_full is low. Results leave on the rsp_ channel:
// the oldest result is shown while rsp_empty is low and is taken with
// rsp_pop. Each item causes no result, one to four decoded bytes, or one
// final result without data that carries the closed or error status.
// Results pass the record queue and the sequencer register on the way out; the
// input takes one byte per cycle while req_full is low. The result side gives
// one result per cycle while rsp_pop is high, so items that expand to several
// bytes are drained at that rate; a four-entry record queue sits between
// decoder and sequencer, and req_full rises once it fills while the receiver
// stalls or drains multi-byte records. The length limit is written on the csr_
// channel, which is always ready. Reset puts the decoder in idle awaiting an
// opening quote, sets the limit to 511 and empties both queue and output.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape_utf8 (
   input  wire        clock,
   input  wire        reset,
   // Input channel
   input  wire        req_push,
   output logic       req_full,
   input  wire [7:0]  req_in_byte,
   input  wire        req_at_end,
   // Result channel
   output logic       rsp_empty,
   input  wire        rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_valid,
   output logic       rsp_out_last,
   output logic [1:0] rsp_status,
   // Configuration channel
   input  wire        csr_valid,
   output logic       csr_ready,
   input  wire [15:0] csr_max_bytes
);

   logic             accept;
   logic             rec_push;
   jsu_pkg::rec_type rec;
   jsu_pkg::rec_type q_data;
   logic             q_empty;
   logic             q_pop;

   assign csr_ready = 1'b1;
   assign accept    = req_push && !req_full;

   // Decoder front end.
   jsu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_byte   (req_in_byte),
      .at_end    (req_at_end),
      .cfg_write (csr_valid && csr_ready),
      .cfg_data  (csr_max_bytes),
      .rec_push  (rec_push),
      .rec       (rec)
   );

   // Record queue.
   jsu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rec_push),
      .push_data (rec),
      .full      (req_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty)
   );

   // Result sequencer.
   jsu_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_data        (q_data),
      .q_empty       (q_empty),
      .q_pop         (q_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_valid (rsp_out_valid),
      .rsp_out_last  (rsp_out_last),
      .rsp_status    (rsp_status)
   );

endmodule

`default_nettype wire

FILE: dv/jsu_decode_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// jsu_decode_checker: result checker for the JSON string unescaper
// Watches the byte input, result and limit-write channels, decodes every
// accepted byte with its own copy of the decoder state, and compares each
// popped result against the oldest predicted one.
// ----------------------------------------------------------------------------

module jsu_decode_checker
   import jsu_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire        req_push,
   input  wire        req_full,
   input  wire [7:0]  req_in_byte,
   input  wire        req_at_end,
   input  wire        rsp_empty,
   input  wire        rsp_pop,
   input  wire [7:0]  rsp_out_byte,
   input  wire        rsp_out_valid,
   input  wire        rsp_out_last,
   input  wire [1:0]  rsp_status,
   input  wire        csr_valid,
   input  wire        csr_ready,
   input  wire [15:0] csr_max_bytes,
   output int         fail_count,
   output int         pending_count
);

   // ASCII ranges of hex digits.
   localparam logic [7:0] ASCII_0  = 8'h30;
   localparam logic [7:0] ASCII_9  = 8'h39;
   localparam logic [7:0] ASCII_UA = 8'h41;
   localparam logic [7:0] ASCII_UF = 8'h46;
   localparam logic [7:0] ASCII_LA = 8'h61;
   localparam logic [7:0] ASCII_LF = 8'h66;

   // UTF-8 lead and continuation markers.
   localparam logic [7:0] UTF8_CONT  = 8'h80;
   localparam logic [7:0] UTF8_LEAD2 = 8'hc0;
   localparam logic [7:0] UTF8_LEAD3 = 8'he0;
   localparam logic [7:0] UTF8_LEAD4 = 8'hf0;

   typedef struct {
      logic [7:0] out_byte;
      logic       out_valid;
      logic       out_last;
      logic [1:0] status;
   } decoded_type;

   decoded_type decoded_q[$];

   // Shadow copy of the decoder state and the length limit.
   logic [2:0]  mode;
   logic [1:0]  hex_left;
   logic [15:0] code_acc;
   logic [9:0]  high_half;
   int          byte_count;
   logic [15:0] limit_reg;

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   task automatic clear_decoder();
      mode       = M_IDLE;
      hex_left   = 2'd0;
      code_acc   = 16'd0;
      high_half  = 10'd0;
      byte_count = 0;
   endtask

   // Decode one accepted byte and queue the results it should cause.
   task automatic decode_byte(input logic [7:0] b, input logic at_end);
      logic [7:0]  dec [4];
      int          n;
      int          hv;
      int          cap;
      logic [1:0]  st;
      logic        encode;
      logic [20:0] cp;
      decoded_type r;
      n      = 0;
      st     = ST_CONT;
      encode = 1'b0;
      cp     = 21'd0;

      if (b >= ASCII_0 && b <= ASCII_9)
         hv = int'(b - ASCII_0);
      else if (b >= ASCII_LA && b <= ASCII_LF)
         hv = int'(b - ASCII_LA) + 10;
      else if (b >= ASCII_UA && b <= ASCII_UF)
         hv = int'(b - ASCII_UA) + 10;
      else
         hv = -1;

      case (mode)
         M_BODY: begin
            if (b == CH_QUOTE)
               st = ST_CLOSED;
            else if (b < CH_CTRL)
               st = ST_ERROR;
            else if (b == CH_BSLASH)
               mode = M_ESC;
            else begin
               dec[0] = b;
               n = 1;
            end
         end
         M_ESC: begin
            mode = M_BODY;
            case (b)
               CH_QUOTE, CH_BSLASH, CH_SLASH: begin
                  dec[0] = b;
                  n = 1;
               end
               CH_B: begin dec[0] = CH_BS;  n = 1; end
               CH_F: begin dec[0] = CH_FF;  n = 1; end
               CH_N: begin dec[0] = CH_LF;  n = 1; end
               CH_R: begin dec[0] = CH_CR;  n = 1; end
               CH_T: begin dec[0] = CH_TAB; n = 1; end
               CH_U: begin
                  mode     = M_HEX1;
                  hex_left = 2'd3;
                  code_acc = 16'd0;
               end
               default: st = ST_ERROR;
            endcase
         end
         M_HEX1, M_HEX2: begin
            if (hv < 0)
               st = ST_ERROR;
            else begin
               code_acc = {code_acc[11:0], 4'(hv)};
               if (hex_left != 2'd0)
                  hex_left = hex_left - 2'd1;
               else if (mode == M_HEX1) begin
                  // First code unit: a high surrogate waits for its partner.
                  if (code_acc >= HI_SUR_LO && code_acc <= HI_SUR_HI) begin
                     high_half = 10'(code_acc - HI_SUR_LO);
                     mode      = M_SBSL;
                  end else if (code_acc >= LO_SUR_LO && code_acc <= LO_SUR_HI)
                     st = ST_ERROR;
                  else begin
                     cp     = 21'(code_acc);
                     encode = 1'b1;
                     mode   = M_BODY;
                  end
               end else begin
                  // Second code unit must be a low surrogate.
                  if (code_acc < LO_SUR_LO || code_acc > LO_SUR_HI)
                     st = ST_ERROR;
                  else begin
                     cp     = 21'h10000 + (21'(high_half) << 10)
                              + 21'(code_acc - LO_SUR_LO);
                     encode = 1'b1;
                     mode   = M_BODY;
                  end
               end
            end
         end
         M_SBSL: begin
            if (b == CH_BSLASH)
               mode = M_SU;
            else
               st = ST_ERROR;
         end
         M_SU: begin
            if (b == CH_U) begin
               mode     = M_HEX2;
               hex_left = 2'd3;
               code_acc = 16'd0;
            end else
               st = ST_ERROR;
         end
         default: begin
            // Idle, and any unused mode code, waits for the opening quote.
            if (b == CH_QUOTE) begin
               clear_decoder();
               mode = M_BODY;
            end else
               st = ST_ERROR;
         end
      endcase

      // Encode a finished code point as UTF-8.
      if (encode) begin
         if (cp <= 21'h7f) begin
            dec[0] = cp[7:0];
            n = 1;
         end else if (cp <= 21'h7ff) begin
            dec[0] = UTF8_LEAD2 | {3'b0, cp[10:6]};
            dec[1] = UTF8_CONT | {2'b0, cp[5:0]};
            n = 2;
         end else if (cp <= 21'hffff) begin
            dec[0] = UTF8_LEAD3 | {4'b0, cp[15:12]};
            dec[1] = UTF8_CONT | {2'b0, cp[11:6]};
            dec[2] = UTF8_CONT | {2'b0, cp[5:0]};
            n = 3;
         end else begin
            dec[0] = UTF8_LEAD4 | {5'b0, cp[20:18]};
            dec[1] = UTF8_CONT | {2'b0, cp[17:12]};
            dec[2] = UTF8_CONT | {2'b0, cp[11:6]};
            dec[3] = UTF8_CONT | {2'b0, cp[5:0]};
            n = 4;
         end
      end

      // Length limit: the smaller of the register and the counter range.
      if (st == ST_CONT && n > 0) begin
         cap = (LEN_BITS >= 31) ? 32'h7fffffff : ((1 << LEN_BITS) - 1);
         if (int'(limit_reg) < cap)
            cap = int'(limit_reg);
         if (byte_count + n > cap)
            st = ST_ERROR;
         else
            byte_count = byte_count + n;
      end
      if (st == ST_CONT && at_end)
         st = ST_ERROR;

      if (st != ST_CONT) begin
         clear_decoder();
         r.out_byte  = 8'd0;
         r.out_valid = 1'b0;
         r.out_last  = 1'b1;
         r.status    = st;
         decoded_q.push_back(r);
      end else begin
         for (int k = 0; k < n; k++) begin
            r.out_byte  = dec[k];
            r.out_valid = 1'b1;
            r.out_last  = (k == n - 1);
            r.status    = ST_CONT;
            decoded_q.push_back(r);
         end
      end
   endtask

   // Results are checked before the item of the same edge is decoded, since
   // a result never shows up in the cycle its item is accepted.
   always @(posedge clock) begin
      decoded_type want;
      if (reset) begin
         clear_decoder();
         limit_reg = MAX_BYTES_RESET;
         decoded_q.delete();
      end else begin
         if (!rsp_empty && rsp_pop) begin
            if (decoded_q.size() == 0) begin
               $error("result item with no prediction waiting: out_byte %02h status %0d",
                      rsp_out_byte, rsp_status);
               fail_count = fail_count + 1;
            end else begin
               want = decoded_q.pop_front();
               if (rsp_out_byte !== want.out_byte) begin
                  $error("out_byte mismatch: expected %02h, actual %02h",
                         want.out_byte, rsp_out_byte);
                  fail_count = fail_count + 1;
               end
               if (rsp_out_valid !== want.out_valid) begin
                  $error("out_valid mismatch: expected %0b, actual %0b",
                         want.out_valid, rsp_out_valid);
                  fail_count = fail_count + 1;
               end
               if (rsp_out_last !== want.out_last) begin
                  $error("out_last mismatch: expected %0b, actual %0b",
                         want.out_last, rsp_out_last);
                  fail_count = fail_count + 1;
               end
               if (rsp_status !== want.status) begin
                  $error("status mismatch: expected %0d, actual %0d",
                         want.status, rsp_status);
                  fail_count = fail_count + 1;
               end
            end
         end
         if (csr_valid && csr_ready)
            limit_reg = csr_max_bytes;
         if (req_push && !req_full)
            decode_byte(req_in_byte, req_at_end);
      end
      pending_count = decoded_q.size();
   end

endmodule

FILE: dv/tb_json_string_unescape_utf8.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_json_string_unescape_utf8: testbench for the JSON string unescaper
// Feeds directed and random quoted strings, well formed and broken, under
// several length limits with random stalls on both channels, and lets the
// checker compare every decoded result.
// ----------------------------------------------------------------------------

module tb_json_string_unescape_utf8;
   import jsu_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 300;

   localparam logic [7:0] ASCII_0  = 8'h30;
   localparam logic [7:0] ASCII_UA = 8'h41;
   localparam logic [7:0] ASCII_LA = 8'h61;
   localparam logic [7:0] ASCII_UG = 8'h47;
   localparam logic [7:0] ASCII_X  = 8'h78;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_in_byte = 8'd0;
   logic        req_at_end = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_out_valid;
   logic        rsp_out_last;
   logic [1:0]  rsp_status;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_max_bytes = 16'd0;
   int          fail_count;
   int          pending_count;

   int          idle_pct = 0;
   logic        hold_rsp = 1'b0;
   int          items_sent = 0;
   int          quiet_cycles = 0;

   json_string_unescape_utf8 u_dut (.*);

   jsu_decode_checker u_checker (.*);

   always #5 clock = ~clock;

   // Mostly short gaps, now and then a long one; none when idle_pct is 0.
   function automatic int pick_gap();
      if ($urandom_range(99) >= idle_pct)
         return 0;
      if ($urandom_range(9) == 0)
         return $urandom_range(20, 60);
      return $urandom_range(1, 3);
   endfunction

   function automatic logic [7:0] pick_plain();
      logic [7:0] b;
      do
         b = 8'($urandom_range(8'h20, 8'hff));
      while (b == CH_QUOTE || b == CH_BSLASH);
      return b;
   endfunction

   // Offer one item and hold it until accepted; called and left at a falling edge.
   task automatic offer_byte(input logic [7:0] b, input logic e);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push    <= 1'b1;
      req_in_byte <= b;
      req_at_end  <= e;
      do
         @(posedge clock);
      while (req_full);
      items_sent++;
      @(negedge clock);
   endtask

   // Send a \uXXXX escape with hex digits in random case.
   task automatic send_code_unit(input logic [15:0] cu);
      logic [3:0] nib;
      logic [7:0] chr;
      offer_byte(CH_BSLASH, 1'b0);
      offer_byte(CH_U, 1'b0);
      for (int i = 3; i >= 0; i--) begin
         nib = cu[i*4 +: 4];
         if (nib < 4'd10)
            chr = ASCII_0 + 8'(nib);
         else
            chr = ($urandom_range(1) ? ASCII_UA : ASCII_LA) + 8'(nib) - 8'd10;
         offer_byte(chr, 1'b0);
      end
   endtask

   // One quoted string; a broken one stops at a fault instead of closing.
   task automatic send_json_string(input logic broken);
      int         ntok;
      int         fault_at;
      logic [7:0] b;
      logic [7:0] esc_set [8];
      esc_set = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};
      ntok = ($urandom_range(7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
      fault_at = broken ? $urandom_range(0, ntok) : -1;
      offer_byte(CH_QUOTE, 1'b0);
      for (int t = 0; t <= ntok; t++) begin
         if (t == fault_at) begin
            case ($urandom_range(7))
               0: offer_byte(8'($urandom_range(0, 31)), 1'b0);
               1: begin
                  // Unknown escape letter.
                  b = 8'($urandom_range(255));
                  if (b == CH_U)
                     b = ASCII_X;
                  foreach (esc_set[i])
                     if (b == esc_set[i])
                        b = ASCII_X;
                  offer_byte(CH_BSLASH, 1'b0);
                  offer_byte(b, 1'b0);
               end
               2: begin
                  // Non-hex digit inside a \u escape.
                  b = 8'($urandom_range(255));
                  if ((b >= ASCII_0 && b < ASCII_0 + 8'd10)
                      || (b >= ASCII_UA && b < ASCII_UG)
                      || (b >= ASCII_LA && b < ASCII_LA + 8'd6))
                     b = ASCII_UG;
                  offer_byte(CH_BSLASH, 1'b0);
                  offer_byte(CH_U, 1'b0);
                  repeat ($urandom_range(0, 3))
                     offer_byte(ASCII_0 + 8'($urandom_range(9)), 1'b0);
                  offer_byte(b, 1'b0);
               end
               3: send_code_unit(16'($urandom_range(16'hdc00, 16'hdfff)));
               4: begin
                  send_code_unit(16'($urandom_range(16'hd800, 16'hdbff)));
                  offer_byte(8'($urandom_range(8'h20, 8'h5b)), 1'b0);
               end
               5: begin
                  send_code_unit(16'($urandom_range(16'hd800, 16'hdbff)));
                  offer_byte(CH_BSLASH, 1'b0);
                  offer_byte(CH_N, 1'b0);
               end
               6: begin
                  send_code_unit(16'($urandom_range(16'hd800, 16'hdbff)));
                  send_code_unit(16'($urandom_range(0, 16'hdbff)));
               end
               default: offer_byte(pick_plain(), 1'b1);
            endcase
            return;
         end
         if (t == ntok)
            break;
         case ($urandom_range(9))
            4: offer_byte(CH_BSLASH, 1'b0);
            5, 6: begin
               case ($urandom_range(2))
                  0: send_code_unit(16'($urandom_range(0, 16'h7f)));
                  1: send_code_unit(16'($urandom_range(16'h80, 16'h7ff)));
                  default: send_code_unit($urandom_range(1) ?
                                          16'($urandom_range(16'h800, 16'hd7ff)) :
                                          16'($urandom_range(16'he000, 16'hffff)));
               endcase
            end
            7, 8: begin
               send_code_unit(16'($urandom_range(16'hd800, 16'hdbff)));
               send_code_unit(16'($urandom_range(16'hdc00, 16'hdfff)));
            end
            default: offer_byte(pick_plain(), 1'b0);
         endcase
         // A lone backslash above is completed by a valid escape letter.
         if (req_in_byte == CH_BSLASH && req_push)
            offer_byte(esc_set[$urandom_range(7)], 1'b0);
      end
      offer_byte(CH_QUOTE, $urandom_range(3) == 0);
   endtask

   task automatic run_phase(input int count);
      int target;
      target = items_sent + count;
      while (items_sent < target) begin
         case ($urandom_range(9))
            6, 7, 8: send_json_string(1'b1);
            9: offer_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
            default: send_json_string(1'b0);
         endcase
      end
   endtask

   // Write the limit only once no result is outstanding.
   task automatic write_limit(input logic [15:0] value);
      req_push <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
      csr_valid     <= 1'b1;
      csr_max_bytes <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Result side: random pops, plus one long hold on request.
   initial begin
      int stall;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            stall = HOLD_CYCLES;
         end else
            stall = pick_gap();
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_pop <= 1'b1;
      end
   end

   // Count cycles in which no channel moves anything.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)
          || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT)
         @(posedge clock);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: idle errors, control byte, pass-through, escapes, a
      // surrogate pair and a close that carries the end flag.
      idle_pct = 30;
      offer_byte(ASCII_X, 1'b0);
      offer_byte(CH_QUOTE, 1'b1);
      offer_byte(CH_QUOTE, 1'b0);
      offer_byte(8'h1f, 1'b0);
      offer_byte(CH_QUOTE, 1'b0);
      offer_byte(8'hff, 1'b0);
      offer_byte(8'h20, 1'b0);
      offer_byte(CH_BSLASH, 1'b0);
      offer_byte(CH_B, 1'b0);
      send_code_unit(16'hd83d);
      send_code_unit(16'hde00);
      offer_byte(CH_QUOTE, 1'b1);
      run_phase(20);

      // Widest limit, no idling, and a long receiver hold so the block fills.
      write_limit(16'hffff);
      idle_pct = 0;
      hold_rsp = 1'b1;
      run_phase(25);

      // Zero limit: every decoded byte overflows.
      write_limit(16'd0);
      idle_pct = 50;
      run_phase(10);

      // Small limits hit the overflow inside a string.
      write_limit(16'($urandom_range(1, 12)));
      idle_pct = 30;
      run_phase(25);

      write_limit(16'($urandom_range(16'hffff)));
      idle_pct = 20;
      run_phase(20);

      write_limit(MAX_BYTES_RESET);
      idle_pct = 40;
      run_phase(20);

      req_push <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      repeat (10) @(negedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
